FILE: hdl/clsv_pkg.sv
// ----------------------------------------------------------------------------
// clsv_pkg: shared constants, types and helpers of the Cholesky solver
// Fixed-point format, store geometry and the triangle address function.
// ----------------------------------------------------------------------------
package clsv_pkg;

  localparam int MAX_ORDER = 8;
  localparam int FRAC_BITS = 16;
  localparam int TRI_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int IDX_W     = 3;
  localparam int ORD_W     = 4;
  localparam int ADDR_W    = 6;
  localparam int VAL_W     = 32;
  localparam int ACC_W     = 64;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam val_t VAL_MAX = 32'sh7fff_ffff;
  localparam val_t VAL_MIN = 32'sh8000_0000;

  // packed lower-triangle address: r*(r+1)/2 + c
  function automatic logic [ADDR_W-1:0] tri_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    logic [ADDR_W-1:0] rr;
    rr = ADDR_W'(r);
    return ADDR_W'((rr * (rr + 1'b1)) >> 1) + ADDR_W'(c);
  endfunction

endpackage

FILE: hdl/clsv_div.sv
// ----------------------------------------------------------------------------
// clsv_div: iterative fixed-point divider
// Returns (num << FRAC_BITS) / den truncated toward zero, saturated to 32 bits.
// One quotient bit per cycle after a magnitude and range check.
// ----------------------------------------------------------------------------
module clsv_div
  import clsv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  acc_t        num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output val_t        quo_o
);

  localparam int QW = VAL_W - 1;
  localparam int SH = QW - FRAC_BITS;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_CHK  = 3'b010,
    D_RUN  = 3'b100
  } div_state_e;

  div_state_e         state_q;
  logic               neg_q;
  logic [ACC_W-1:0]   mag_q;
  logic [31:0]        den_q;
  logic [31:0]        rem_q;
  logic [QW-1:0]      shin_q;
  logic [QW-1:0]      quo_bits_q;
  logic [4:0]         cnt_q;
  logic               done_q;
  val_t               quo_q;

  logic [ACC_W-SH-1:0] head;
  logic [32:0]         trial;
  logic                ge;
  logic [QW-1:0]       quo_next;

  assign head     = mag_q[ACC_W-1:SH];
  assign trial    = {rem_q, shin_q[QW-1]};
  assign ge       = trial >= {1'b0, den_q};
  assign quo_next = {quo_bits_q[QW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            state_q <= D_CHK;
          end
        end
        D_CHK: begin
          cnt_q <= '0;
          if (head >= (ACC_W-SH)'(den_q)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else begin
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(QW - 1)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          neg_q <= num_i[ACC_W-1];
          mag_q <= num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
          den_q <= den_i;
        end
      end
      D_CHK: begin
        rem_q      <= head[31:0];
        shin_q     <= {mag_q[SH-1:0], {FRAC_BITS{1'b0}}};
        quo_bits_q <= '0;
        if (head >= (ACC_W-SH)'(den_q)) begin
          quo_q <= neg_q ? VAL_MIN : VAL_MAX;
        end
      end
      D_RUN: begin
        rem_q      <= ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
        shin_q     <= {shin_q[QW-2:0], 1'b0};
        quo_bits_q <= quo_next;
        if (cnt_q == 5'(QW - 1)) begin
          quo_q <= neg_q ? -val_t'({1'b0, quo_next}) : val_t'({1'b0, quo_next});
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hdl/clsv_sqrt.sv
// ----------------------------------------------------------------------------
// clsv_sqrt: iterative fixed-point square root
// Returns floor(sqrt(d << FRAC_BITS)) saturated to 2^31-1, one root bit a cycle.
// ----------------------------------------------------------------------------
module clsv_sqrt
  import clsv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  acc_t rad_i,
  output logic done_o,
  output val_t root_o
);

  logic             run_q;
  logic [4:0]       cnt_q;
  logic             done_q;
  logic             sat_q;
  logic [ACC_W-1:0] v_q;
  logic [ACC_W-1:0] res_q;
  logic [ACC_W-1:0] bit_q;
  val_t             root_q;

  logic [ACC_W-1:0] sum;
  logic             ge;
  logic [ACC_W-1:0] res_next;

  assign sum      = res_q + bit_q;
  assign ge       = v_q >= sum;
  assign res_next = ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !run_q) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !run_q) begin
      sat_q <= |rad_i[ACC_W-1:ACC_W-1-FRAC_BITS];
      v_q   <= ACC_W'(rad_i) << FRAC_BITS;
      res_q <= '0;
      bit_q <= ACC_W'(1) << (ACC_W - 2);
    end else if (run_q) begin
      if (ge) begin
        v_q <= v_q - sum;
      end
      res_q <= res_next;
      bit_q <= bit_q >> 2;
      if (cnt_q == 5'd31) begin
        root_q <= (sat_q || (res_next[ACC_W-1:VAL_W-1] != '0)) ? VAL_MAX
                                                               : val_t'(res_next[VAL_W-1:0]);
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hdl/cholesky_linear_solve.sv
// Load beats: one per cycle, busy_o stays low. The beat marked last starts the solve.
// Solve: each product term passes through the shared read, multiply and accumulate states;
// divides, which end early on saturation, and square roots run in the bit-serial units.
// Results: each strobe is raised from an output state that follows a read state.
// Reset (rst_ni low, asynchronous): sequencer idle, order 1; stores are undefined.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// cholesky_linear_solve: fixed-point Cholesky factorization and linear solve
// Factors the loaded matrix as L*L^T, emits L, then solves by forward and back
// substitution and emits x, using one multiplier and shared divide/root units.
// ----------------------------------------------------------------------------
module cholesky_linear_solve
  import clsv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             cfg_we_i,
  input  logic [ORD_W-1:0] cfg_wdata_i,
  input  logic             operation_i,
  input  logic [IDX_W-1:0] row_index_i,
  input  logic [IDX_W-1:0] col_index_i,
  input  val_t             element_value_i,
  input  logic             last_element_i,
  output logic             result_valid_o,
  output logic             result_kind_o,
  output logic [IDX_W-1:0] out_row_o,
  output logic [IDX_W-1:0] out_col_o,
  output val_t             out_value_o,
  output logic             status_o,
  output logic             last_result_o
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00_0000_0000_0001,
    S_INIT  = 14'b00_0000_0000_0010,
    S_MRD   = 14'b00_0000_0000_0100,
    S_MMUL  = 14'b00_0000_0000_1000,
    S_MACC  = 14'b00_0000_0001_0000,
    S_BRD   = 14'b00_0000_0010_0000,
    S_BSUB  = 14'b00_0000_0100_0000,
    S_DIV   = 14'b00_0000_1000_0000,
    S_SQRT  = 14'b00_0001_0000_0000,
    S_WR    = 14'b00_0010_0000_0000,
    S_ELRD  = 14'b00_0100_0000_0000,
    S_ELOUT = 14'b00_1000_0000_0000,
    S_EYRD  = 14'b01_0000_0000_0000,
    S_EYOUT = 14'b10_0000_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    MODE_FACT = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_BACK = 2'd2
  } mode_e;

  state_e           state_q;
  mode_e            mode_q;
  logic [ORD_W-1:0] order_q;
  logic [ORD_W-1:0] n_q;
  logic [IDX_W-1:0] i_q;
  logic [IDX_W-1:0] j_q;
  logic [ORD_W-1:0] k_q;
  acc_t             s_q;
  acc_t             prod_q;

  val_t a_mem [TRI_DEPTH];
  val_t l_mem [TRI_DEPTH];
  val_t b_mem [MAX_ORDER];
  val_t y_mem [MAX_ORDER];
  val_t a_rd_q, l_rd0_q, l_rd1_q, b_rd_q, y_rd_q;

  logic        res_valid_q, res_kind_q, res_status_q, res_last_q;
  logic [IDX_W-1:0] res_row_q, res_col_q;
  val_t        res_value_q;

  logic [ADDR_W-1:0] l_ra0, l_ra1;
  logic [IDX_W-1:0]  y_ra;
  logic [ORD_W-1:0]  k_start, k_end, k_inc;
  val_t              op_y, base;
  acc_t              diff;
  logic              is_diag, not_pd;
  logic              div_start, sqrt_start, div_done, sqrt_done;
  val_t              div_quo, sqrt_root, unit_res;
  logic              load_acc;
  logic [ORD_W-1:0]  n_clamped;

  assign load_acc = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);

  always_comb begin
    if (order_q == '0) begin
      n_clamped = ORD_W'(1);
    end else if (order_q > ORD_W'(MAX_ORDER)) begin
      n_clamped = ORD_W'(MAX_ORDER);
    end else begin
      n_clamped = order_q;
    end
  end

  // loop bounds and operand selection per pass
  always_comb begin
    k_start = '0;
    k_end   = {1'b0, j_q};
    op_y    = l_rd1_q;
    base    = a_rd_q;
    l_ra0   = tri_addr(i_q, k_q[IDX_W-1:0]);
    unique case (mode_q)
      MODE_FACT: begin
        if (state_q == S_BRD) begin
          l_ra0 = tri_addr(j_q, j_q);
        end
      end
      MODE_FWD: begin
        k_end = {1'b0, i_q};
        op_y  = y_rd_q;
        base  = b_rd_q;
        if (state_q == S_BRD) begin
          l_ra0 = tri_addr(i_q, i_q);
        end
      end
      MODE_BACK: begin
        k_start = {1'b0, i_q} + 1'b1;
        k_end   = n_q;
        op_y    = y_rd_q;
        base    = y_rd_q;
        l_ra0   = (state_q == S_BRD) ? tri_addr(i_q, i_q)
                                     : tri_addr(k_q[IDX_W-1:0], i_q);
      end
      default: ;
    endcase
    if (state_q == S_ELRD) begin
      l_ra0 = tri_addr(i_q, j_q);
    end
  end

  assign l_ra1    = tri_addr(j_q, k_q[IDX_W-1:0]);
  assign y_ra     = (state_q == S_MRD) ? k_q[IDX_W-1:0] : i_q;
  assign k_inc    = k_q + 1'b1;
  assign diff     = acc_t'(base) - s_q;
  assign is_diag  = (mode_q == MODE_FACT) && (j_q == i_q);
  assign not_pd   = diff[ACC_W-1] || (diff == '0);
  assign div_start  = (state_q == S_BSUB) && !is_diag;
  assign sqrt_start = (state_q == S_BSUB) && is_diag && !not_pd;
  assign unit_res   = is_diag ? sqrt_root : div_quo;

  // stores: registered reads every cycle
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      if (operation_i) begin
        b_mem[row_index_i] <= element_value_i;
      end else if (col_index_i <= row_index_i) begin
        a_mem[tri_addr(row_index_i, col_index_i)] <= element_value_i;
      end
    end
    if (state_q == S_WR) begin
      if (mode_q == MODE_FACT) begin
        l_mem[tri_addr(i_q, j_q)] <= unit_res;
      end else begin
        y_mem[i_q] <= unit_res;
      end
    end
    a_rd_q  <= a_mem[tri_addr(i_q, j_q)];
    l_rd0_q <= l_mem[l_ra0];
    l_rd1_q <= l_mem[l_ra1];
    b_rd_q  <= b_mem[i_q];
    y_rd_q  <= y_mem[y_ra];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MMUL) begin
      prod_q <= l_rd0_q * op_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_FACT;
      order_q     <= ORD_W'(1);
      n_q         <= ORD_W'(1);
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      s_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (load_acc && last_element_i) begin
            n_q     <= n_clamped;
            mode_q  <= MODE_FACT;
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          k_q     <= k_start;
          s_q     <= '0;
          state_q <= (k_start < k_end) ? S_MRD : S_BRD;
        end
        S_MRD:  state_q <= S_MMUL;
        S_MMUL: state_q <= S_MACC;
        S_MACC: begin
          s_q     <= s_q + (prod_q >>> FRAC_BITS);
          k_q     <= k_inc;
          state_q <= (k_inc < k_end) ? S_MRD : S_BRD;
        end
        S_BRD: state_q <= S_BSUB;
        S_BSUB: begin
          if (is_diag && not_pd) begin
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= is_diag ? S_SQRT : S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_WR;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            state_q <= S_WR;
          end
        end
        S_WR: begin
          unique case (mode_q)
            MODE_FACT: begin
              if (j_q != i_q) begin
                j_q     <= j_q + 1'b1;
                state_q <= S_INIT;
              end else if ({1'b0, i_q} + 1'b1 < n_q) begin
                i_q     <= i_q + 1'b1;
                j_q     <= '0;
                state_q <= S_INIT;
              end else begin
                i_q     <= '0;
                j_q     <= '0;
                state_q <= S_ELRD;
              end
            end
            MODE_FWD: begin
              state_q <= S_INIT;
              if ({1'b0, i_q} + 1'b1 < n_q) begin
                i_q <= i_q + 1'b1;
              end else begin
                mode_q <= MODE_BACK;
                i_q    <= IDX_W'(n_q - 1'b1);
              end
            end
            MODE_BACK: begin
              if (i_q != '0) begin
                i_q     <= i_q - 1'b1;
                state_q <= S_INIT;
              end else begin
                state_q <= S_EYRD;
              end
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_ELRD: state_q <= S_ELOUT;
        S_ELOUT: begin
          res_valid_q <= 1'b1;
          if (j_q != i_q) begin
            j_q     <= j_q + 1'b1;
            state_q <= S_ELRD;
          end else if ({1'b0, i_q} + 1'b1 < n_q) begin
            i_q     <= i_q + 1'b1;
            j_q     <= '0;
            state_q <= S_ELRD;
          end else begin
            mode_q  <= MODE_FWD;
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_INIT;
          end
        end
        S_EYRD: state_q <= S_EYOUT;
        S_EYOUT: begin
          res_valid_q <= 1'b1;
          if ({1'b0, i_q} + 1'b1 < n_q) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_EYRD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_BSUB: begin
        res_kind_q   <= 1'b0;
        res_row_q    <= i_q;
        res_col_q    <= i_q;
        res_value_q  <= '0;
        res_status_q <= 1'b1;
        res_last_q   <= 1'b1;
      end
      S_ELOUT: begin
        res_kind_q   <= 1'b0;
        res_row_q    <= i_q;
        res_col_q    <= j_q;
        res_value_q  <= l_rd0_q;
        res_status_q <= 1'b0;
        res_last_q   <= 1'b0;
      end
      S_EYOUT: begin
        res_kind_q   <= 1'b1;
        res_row_q    <= i_q;
        res_col_q    <= '0;
        res_value_q  <= y_rd_q;
        res_status_q <= 1'b0;
        res_last_q   <= ({1'b0, i_q} + 1'b1 == n_q);
      end
      default: ;
    endcase
  end

  clsv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (diff),
    .den_i   (l_rd0_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  clsv_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (diff),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign result_valid_o = res_valid_q;
  assign result_kind_o  = res_kind_q;
  assign out_row_o      = res_row_q;
  assign out_col_o      = res_col_q;
  assign out_value_o    = res_value_q;
  assign status_o       = res_status_q;
  assign last_result_o  = res_last_q;

`ifndef SYNTHESIS
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_element_i) |=> busy_o)
    else $error("solve did not start on last load beat");

  a_unit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_start && sqrt_start))
    else $error("divider and root unit started together");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o) |-> last_result_o)
    else $error("error beat not marked last");

  a_done_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_done) |=> (state_q == S_WR))
    else $error("divide result not written back");
`endif

endmodule
